>>> sv/tlbw_pkg.sv
// Shared types and constants for the translation buffer with two-level page walk.
// No dependencies; every other file imports this package.
package tlbw_pkg;

    localparam int ENTRIES = 64;
    localparam int SLOT_W  = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int TAG_W   = 20;
    localparam int OFF_W   = 12;
    localparam int IDX_W   = 10;

    localparam int QDEPTH  = 2;
    localparam int QPTR_W  = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
    localparam int QCNT_W  = $clog2(QDEPTH + 1);

    typedef enum logic {
        KIND_REQ   = 1'b0,
        KIND_REPLY = 1'b1
    } t_kind;

    typedef enum logic [2:0] {
        ST_DONE   = 3'd0,
        ST_READ   = 3'd1,
        ST_NODIR  = 3'd2,
        ST_NOPAGE = 3'd3,
        ST_REJECT = 3'd4
    } t_status;

    typedef struct packed {
        t_kind       kind;
        logic [31:0] lin_addr;
        logic [31:0] read_data;
    } t_item;

    // queue head as seen by the back end
    typedef struct packed {
        logic  valid;
        t_item item;
    } t_head;

endpackage

>>> sv/tlbw_front.sv
// Front end: accepts items, classifies them by kind and holds them in a short queue.
// Depends on tlbw_pkg.
module tlbw_front (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                start,
    output logic                busy,
    input  logic                i_kind,
    input  logic [31:0]         i_lin_addr,
    input  logic [31:0]         i_read_data,
    input  logic                i_pop,
    output tlbw_pkg::t_head     o_head
);
    import tlbw_pkg::*;

    t_item             r_item [QDEPTH];
    logic [QPTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [QPTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [QCNT_W-1:0] r_count, n_count;
    logic              w_push;
    logic              w_pop;
    t_item             w_new;

    assign busy   = (r_count == QCNT_W'(QDEPTH));
    assign w_push = start && !busy;
    assign w_pop  = i_pop && (r_count != '0);

    always_comb begin
        w_new.kind      = i_kind ? KIND_REPLY : KIND_REQ;
        w_new.lin_addr  = i_lin_addr;
        w_new.read_data = i_read_data;
    end

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (w_push) begin
            n_wr_ptr = (r_wr_ptr == QPTR_W'(QDEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (w_pop) begin
            n_rd_ptr = (r_rd_ptr == QPTR_W'(QDEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        case ({w_push, w_pop})
            2'b10:   n_count = r_count + 1'b1;
            2'b01:   n_count = r_count - 1'b1;
            default: n_count = r_count;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_item[r_wr_ptr] <= w_new;
        end
    end

    assign o_head.valid = (r_count != '0);
    assign o_head.item  = r_item[r_rd_ptr];

endmodule

>>> sv/tlbw_back.sv
// Back end: buffer lookup, page walk sequencing, buffer fill and result register.
// Depends on tlbw_pkg.
module tlbw_back (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  tlbw_pkg::t_head     i_head,
    output logic                o_pop,
    input  logic [19:0]         i_dir_base,
    output logic                o_strobe,
    output logic [2:0]          o_status,
    output logic [31:0]         o_address,
    output logic                o_tlb_hit
);
    import tlbw_pkg::*;

    typedef enum logic [2:0] {
        B_IDLE = 3'b001,
        B_EVAL = 3'b010,
        B_HIT  = 3'b100
    } t_bstate;

    typedef enum logic [2:0] {
        PH_IDLE  = 3'b001,
        PH_DIR   = 3'b010,
        PH_TABLE = 3'b100
    } t_phase;

    t_bstate            r_state, n_state;
    t_phase             r_phase, n_phase;
    t_item              r_cur;
    logic [31:0]        r_pending, n_pending;
    logic [ENTRIES-1:0] r_valid;
    logic [TAG_W-1:0]   r_tag [ENTRIES];
    logic [TAG_W-1:0]   r_frame_mem [ENTRIES];
    logic [TAG_W-1:0]   r_frame_q;

    logic               r_strobe, n_strobe;
    t_status            r_status, n_status;
    logic [31:0]        r_address, n_address;
    logic               r_hit, n_hit;

    logic [ENTRIES-1:0] w_match;
    logic               w_any_hit;
    logic [SLOT_W-1:0]  w_hit_idx;
    logic [SLOT_W-1:0]  w_free_idx;
    logic               w_fill;
    logic               w_rd_en;

    // parallel tag compare; lowest matching slot wins
    always_comb begin
        w_hit_idx = '0;
        for (int i = 0; i < ENTRIES; i++) begin
            w_match[i] = r_valid[i] && (r_tag[i] == r_cur.lin_addr[31:OFF_W]);
        end
        for (int i = ENTRIES - 1; i >= 0; i--) begin
            if (w_match[i]) begin
                w_hit_idx = SLOT_W'(i);
            end
        end
        w_any_hit = |w_match;
    end

    // first free slot, slot 0 when the buffer is full
    always_comb begin
        w_free_idx = '0;
        for (int i = ENTRIES - 1; i >= 0; i--) begin
            if (!r_valid[i]) begin
                w_free_idx = SLOT_W'(i);
            end
        end
    end

    always_comb begin
        n_state   = r_state;
        n_phase   = r_phase;
        n_pending = r_pending;
        n_strobe  = 1'b0;
        n_status  = r_status;
        n_address = r_address;
        n_hit     = 1'b0;
        o_pop     = 1'b0;
        w_fill    = 1'b0;
        w_rd_en   = 1'b0;
        unique case (r_state)
            B_IDLE: begin
                if (i_head.valid) begin
                    o_pop   = 1'b1;
                    n_state = B_EVAL;
                end
            end
            B_EVAL: begin
                n_state  = B_IDLE;
                n_strobe = 1'b1;
                unique case (r_phase)
                    PH_DIR: begin
                        if (r_cur.kind == KIND_REQ) begin
                            n_status  = ST_REJECT;
                            n_address = '0;
                        end else if (!r_cur.read_data[0]) begin
                            n_status  = ST_NODIR;
                            n_address = r_pending;
                            n_phase   = PH_IDLE;
                        end else begin
                            n_status  = ST_READ;
                            n_address = {r_cur.read_data[31:OFF_W],
                                         r_pending[OFF_W+IDX_W-1:OFF_W], 2'b00};
                            n_phase   = PH_TABLE;
                        end
                    end
                    PH_TABLE: begin
                        if (r_cur.kind == KIND_REQ) begin
                            n_status  = ST_REJECT;
                            n_address = '0;
                        end else begin
                            n_phase = PH_IDLE;
                            if (!r_cur.read_data[0]) begin
                                n_status  = ST_NOPAGE;
                                n_address = r_pending;
                            end else begin
                                w_fill    = 1'b1;
                                n_status  = ST_DONE;
                                n_address = {r_cur.read_data[31:OFF_W],
                                             r_pending[OFF_W-1:0]};
                            end
                        end
                    end
                    default: begin
                        n_phase = PH_IDLE;
                        if (r_cur.kind == KIND_REPLY) begin
                            n_status  = ST_REJECT;
                            n_address = '0;
                        end else if (w_any_hit) begin
                            // fetch the frame from the frame store, answer from B_HIT
                            w_rd_en  = 1'b1;
                            n_strobe = 1'b0;
                            n_state  = B_HIT;
                        end else begin
                            n_status  = ST_READ;
                            n_address = {i_dir_base, r_cur.lin_addr[31:OFF_W+IDX_W], 2'b00};
                            n_pending = r_cur.lin_addr;
                            n_phase   = PH_DIR;
                        end
                    end
                endcase
            end
            B_HIT: begin
                n_strobe  = 1'b1;
                n_status  = ST_DONE;
                n_address = {r_frame_q, r_cur.lin_addr[OFF_W-1:0]};
                n_hit     = 1'b1;
                n_state   = B_IDLE;
            end
            default: begin
                n_state = B_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= B_IDLE;
            r_phase   <= PH_IDLE;
            r_pending <= '0;
            r_valid   <= '0;
            r_strobe  <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_phase   <= n_phase;
            r_pending <= n_pending;
            r_strobe  <= n_strobe;
            if (w_fill) begin
                r_valid[w_free_idx] <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_status  <= n_status;
        r_address <= n_address;
        r_hit     <= n_hit;
        if (o_pop) begin
            r_cur <= i_head.item;
        end
        if (w_fill) begin
            r_tag[w_free_idx] <= r_pending[31:OFF_W];
        end
    end

    // frame store: one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (w_fill) begin
            r_frame_mem[w_free_idx] <= r_cur.read_data[31:OFF_W];
        end
        if (w_rd_en) begin
            r_frame_q <= r_frame_mem[w_hit_idx];
        end
    end

    assign o_strobe  = r_strobe;
    assign o_status  = r_status;
    assign o_address = r_address;
    assign o_tlb_hit = r_hit;

endmodule

>>> sv/tlb_with_two_level_page_walk.sv
// Top level: directory base register, front end queue and back end walker.
// Depends on tlbw_pkg, tlbw_front and tlbw_back.
//
// An item is taken when start is high and busy is low; busy rises only when the
// two-entry queue between front and back end is full. The back end handles one
// item at a time and takes the next from the queue once the last is finished, a
// buffer hit taking one more state. A buffer hit gives its result after pop, tag
// compare and frame store read; every other item after pop and evaluation. Each
// result shows on o_strobe for a single cycle and cannot be held off, so the
// receiver must take it then. A miss answers with a memory read request; the
// memory reply is sent back in as an item of kind 1.
// Configuration writes are always ready and should be made only while idle.
module tlb_with_two_level_page_walk (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic        i_kind,
    input  logic [31:0] i_lin_addr,
    input  logic [31:0] i_read_data,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [19:0] i_cfg_data,
    output logic        o_strobe,
    output logic [2:0]  o_status,
    output logic [31:0] o_address,
    output logic        o_tlb_hit
);
    import tlbw_pkg::*;

    logic [19:0] r_dir_base;
    t_head       w_head;
    logic        w_pop;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dir_base <= '0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_dir_base <= i_cfg_data;
        end
    end

    tlbw_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .busy        (busy),
        .i_kind      (i_kind),
        .i_lin_addr  (i_lin_addr),
        .i_read_data (i_read_data),
        .i_pop       (w_pop),
        .o_head      (w_head)
    );

    tlbw_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_head     (w_head),
        .o_pop      (w_pop),
        .i_dir_base (r_dir_base),
        .o_strobe   (o_strobe),
        .o_status   (o_status),
        .o_address  (o_address),
        .o_tlb_hit  (o_tlb_hit)
    );

endmodule

>>> sim/tlb_with_two_level_page_walk_tb.sv
// Self-checking testbench for the translation buffer with two-level page walk.
// Depends on tlbw_pkg and tlb_with_two_level_page_walk; a directed table, then
// randomised walks, hits and out-of-turn items under several directory bases.
module tlb_with_two_level_page_walk_tb;
    import tlbw_pkg::*;

    localparam int PHASE_ITEMS = 210;
    localparam int SETTLE_CYCLES = 8;

    typedef enum logic [1:0] {
        WALK_IDLE  = 2'd0,
        WALK_DIR   = 2'd1,
        WALK_TABLE = 2'd2
    } t_walk_state;

    typedef struct packed {
        t_status     status;
        logic [31:0] address;
        logic        hit;
    } t_xlat_result;

    typedef struct packed {
        t_kind        kind;
        logic [31:0]  lin;
        logic [31:0]  data;
        logic         typed;
        t_xlat_result want;
    } t_stim_row;

    logic        i_clk;
    logic        i_rst_n;
    logic        start;
    logic        busy;
    logic        i_kind;
    logic [31:0] i_lin_addr;
    logic [31:0] i_read_data;
    logic        i_cfg_valid;
    logic        o_cfg_ready;
    logic [19:0] i_cfg_data;
    logic        o_strobe;
    logic [2:0]  o_status;
    logic [31:0] o_address;
    logic        o_tlb_hit;

    // translation state as the block should hold it
    logic        slot_valid [ENTRIES];
    logic [19:0] slot_tag   [ENTRIES];
    logic [19:0] slot_frame [ENTRIES];
    t_walk_state walk;
    logic [31:0] pend_addr;
    logic [19:0] base_frame;

    t_xlat_result pending_results [$];

    int errors;
    int items_sent;
    int n_done;
    int n_hits;
    int n_reads;
    int n_faults;
    int n_rejects;
    int cfg_writes;
    bit idle_on;

    // extremes, every fault and out-of-turn items; typed rows read off at a glance
    t_stim_row directed_rows [0:19] = '{
        '{KIND_REPLY, 32'h0000_0000, 32'hFFFF_FFFF, 1'b1, '{ST_REJECT, 32'h0000_0000, 1'b0}},
        '{KIND_REQ,   32'hFFFF_FFFF, 32'h0000_0000, 1'b1, '{ST_READ,   32'h0000_0FFC, 1'b0}},
        '{KIND_REQ,   32'h1234_5678, 32'h0000_0000, 1'b1, '{ST_REJECT, 32'h0000_0000, 1'b0}},
        '{KIND_REPLY, 32'h0000_0000, 32'hFFFF_F001, 1'b1, '{ST_READ,   32'hFFFF_FFFC, 1'b0}},
        '{KIND_REPLY, 32'h0000_0000, 32'hFFFF_F001, 1'b1, '{ST_DONE,   32'hFFFF_FFFF, 1'b0}},
        '{KIND_REQ,   32'hFFFF_F000, 32'h0000_0000, 1'b1, '{ST_DONE,   32'hFFFF_F000, 1'b1}},
        '{KIND_REQ,   32'h0000_0000, 32'h0000_0000, 1'b1, '{ST_READ,   32'h0000_0000, 1'b0}},
        '{KIND_REPLY, 32'h0000_0000, 32'hFFFF_FFFE, 1'b1, '{ST_NODIR,  32'h0000_0000, 1'b0}},
        '{KIND_REQ,   32'h0040_0ABC, 32'h0000_0000, 1'b1, '{ST_READ,   32'h0000_0004, 1'b0}},
        '{KIND_REPLY, 32'h0000_0000, 32'h0000_0001, 1'b1, '{ST_READ,   32'h0000_0000, 1'b0}},
        '{KIND_REPLY, 32'h0000_0000, 32'h0000_0000, 1'b1, '{ST_NOPAGE, 32'h0040_0ABC, 1'b0}},
        '{KIND_REQ,   32'h0040_0ABC, 32'h0000_0000, 1'b1, '{ST_READ,   32'h0000_0004, 1'b0}},
        '{KIND_REPLY, 32'h0000_0000, 32'hAAAA_A555, 1'b0, '{ST_DONE,   32'h0000_0000, 1'b0}},
        '{KIND_REPLY, 32'h0000_0000, 32'h5555_5FFF, 1'b0, '{ST_DONE,   32'h0000_0000, 1'b0}},
        '{KIND_REQ,   32'h0040_0123, 32'h0000_0000, 1'b0, '{ST_DONE,   32'h0000_0000, 1'b0}},
        '{KIND_REQ,   32'h8000_1FFF, 32'h0000_0000, 1'b0, '{ST_DONE,   32'h0000_0000, 1'b0}},
        '{KIND_REPLY, 32'h0000_0000, 32'h1234_5001, 1'b0, '{ST_DONE,   32'h0000_0000, 1'b0}},
        '{KIND_REPLY, 32'h0000_0000, 32'h0ABC_D001, 1'b0, '{ST_DONE,   32'h0000_0000, 1'b0}},
        '{KIND_REQ,   32'h8000_1000, 32'h0000_0000, 1'b0, '{ST_DONE,   32'h0000_0000, 1'b0}},
        '{KIND_REPLY, 32'h0000_0000, 32'h0000_0000, 1'b1, '{ST_REJECT, 32'h0000_0000, 1'b0}}
    };

    tlb_with_two_level_page_walk dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .busy        (busy),
        .i_kind      (i_kind),
        .i_lin_addr  (i_lin_addr),
        .i_read_data (i_read_data),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (i_cfg_data),
        .o_strobe    (o_strobe),
        .o_status    (o_status),
        .o_address   (o_address),
        .o_tlb_hit   (o_tlb_hit)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #5_000_000;
        $display("%0t: run timed out with %0d results outstanding", $time,
                 pending_results.size());
        $display("FAILURE");
        $finish;
    end

    // advance the translation state by one item and return its result
    function automatic t_xlat_result translate_item(t_kind kind, logic [31:0] lin,
                                                    logic [31:0] data);
        t_xlat_result r;
        int slot;
        r = '{ST_REJECT, 32'h0, 1'b0};
        slot = -1;
        if (walk == WALK_DIR || walk == WALK_TABLE) begin
            if (kind == KIND_REPLY) begin
                if (walk == WALK_DIR) begin
                    if (!data[0]) begin
                        walk = WALK_IDLE;
                        r = '{ST_NODIR, pend_addr, 1'b0};
                    end else begin
                        walk = WALK_TABLE;
                        r = '{ST_READ, {data[31:12], 12'h000} +
                              {20'h0, pend_addr[21:12], 2'b00}, 1'b0};
                    end
                end else begin
                    walk = WALK_IDLE;
                    if (!data[0]) begin
                        r = '{ST_NOPAGE, pend_addr, 1'b0};
                    end else begin
                        // first free slot, else overwrite slot 0
                        slot = 0;
                        for (int i = ENTRIES - 1; i >= 0; i--)
                            if (!slot_valid[i]) slot = i;
                        slot_valid[slot] = 1'b1;
                        slot_tag[slot]   = pend_addr[31:12];
                        slot_frame[slot] = data[31:12];
                        r = '{ST_DONE, {data[31:12], pend_addr[11:0]}, 1'b0};
                    end
                end
            end
        end else if (kind == KIND_REQ) begin
            for (int i = ENTRIES - 1; i >= 0; i--)
                if (slot_valid[i] && slot_tag[i] == lin[31:12]) slot = i;
            if (slot >= 0) begin
                r = '{ST_DONE, {slot_frame[slot], lin[11:0]}, 1'b1};
            end else begin
                pend_addr = lin;
                walk = WALK_DIR;
                r = '{ST_READ, {base_frame, 12'h000} + {20'h0, lin[31:22], 2'b00}, 1'b0};
            end
        end
        return r;
    endfunction

    function automatic int unsigned next_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (!idle_on || r < 50) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(4, 30);
    endfunction

    task automatic send_item(t_kind kind, logic [31:0] lin, logic [31:0] data,
                             logic typed, t_xlat_result want);
        t_xlat_result r;
        int unsigned gap;
        @(negedge i_clk);
        start       <= 1'b1;
        i_kind      <= kind;
        i_lin_addr  <= lin;
        i_read_data <= data;
        do @(posedge i_clk); while (busy);
        r = translate_item(kind, lin, data);
        pending_results.push_back(typed ? want : r);
        items_sent++;
        gap = next_gap();
        if (gap > 0) begin
            @(negedge i_clk);
            start <= 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
    endtask

    // mostly well-formed walks and repeat lookups, with some out-of-turn items
    task automatic random_item();
        t_kind kind;
        logic [31:0] lin;
        logic [31:0] data;
        int s;
        lin  = $urandom;
        data = $urandom;
        if (walk == WALK_IDLE) begin
            if ($urandom_range(0, 99) < 8) kind = KIND_REPLY;
            else kind = KIND_REQ;
            if (kind == KIND_REQ && $urandom_range(0, 99) < 45) begin
                s = $urandom_range(0, ENTRIES - 1);
                if (slot_valid[s]) lin = {slot_tag[s], lin[11:0]};
            end
        end else begin
            if ($urandom_range(0, 99) < 8) kind = KIND_REQ;
            else kind = KIND_REPLY;
            data[0] = ($urandom_range(0, 99) < 88);
        end
        send_item(kind, lin, data, 1'b0, '0);
    endtask

    // drain every outstanding result, then let the pipeline empty
    task automatic settle();
        @(negedge i_clk);
        start <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_dir_base(logic [19:0] value);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
        base_frame = value;
        cfg_writes++;
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    always @(posedge i_clk) begin
        t_xlat_result want;
        if (i_rst_n && o_strobe) begin
            if (pending_results.size() == 0) begin
                $display("%0t: unexpected result status %0d address %h hit %b",
                         $time, o_status, o_address, o_tlb_hit);
                errors++;
            end else begin
                want = pending_results.pop_front();
                if (o_status !== want.status) begin
                    $display("%0t: status expected %0d actual %0d", $time,
                             want.status, o_status);
                    errors++;
                end
                if (o_address !== want.address) begin
                    $display("%0t: address expected %h actual %h", $time,
                             want.address, o_address);
                    errors++;
                end
                if (o_tlb_hit !== want.hit) begin
                    $display("%0t: tlb_hit expected %b actual %b", $time,
                             want.hit, o_tlb_hit);
                    errors++;
                end
            end
            case (o_status) inside
                ST_DONE: begin
                    n_done++;
                    if (o_tlb_hit) n_hits++;
                end
                ST_READ:   n_reads++;
                ST_NODIR,
                ST_NOPAGE: n_faults++;
                default:   n_rejects++;
            endcase
        end
    end

    initial begin
        logic [19:0] bases [4];
        start       = 1'b0;
        i_kind      = 1'b0;
        i_lin_addr  = 32'h0;
        i_read_data = 32'h0;
        i_cfg_valid = 1'b0;
        i_cfg_data  = 20'h0;
        i_rst_n     = 1'b0;
        errors      = 0;
        items_sent  = 0;
        n_done      = 0;
        n_hits      = 0;
        n_reads     = 0;
        n_faults    = 0;
        n_rejects   = 0;
        cfg_writes  = 0;
        idle_on     = 1'b1;
        walk        = WALK_IDLE;
        pend_addr   = 32'h0;
        base_frame  = 20'h0;
        for (int i = 0; i < ENTRIES; i++) begin
            slot_valid[i] = 1'b0;
            slot_tag[i]   = 20'h0;
            slot_frame[i] = 20'h0;
        end
        bases[0] = 20'hFFFFF;
        bases[1] = 20'($urandom);
        bases[2] = 20'h00000;
        bases[3] = 20'($urandom);

        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directory base left at its reset value for the table
        foreach (directed_rows[k])
            send_item(directed_rows[k].kind, directed_rows[k].lin, directed_rows[k].data,
                      directed_rows[k].typed, directed_rows[k].want);

        for (int ph = 0; ph < 4; ph++) begin
            settle();
            write_dir_base(bases[ph]);
            // one phase back to back to keep the queue full
            idle_on = (ph != 1);
            repeat (PHASE_ITEMS) random_item();
        end

        settle();
        $display("Sent %0d items over %0d directory bases: %0d translations (%0d hits),",
                 items_sent, cfg_writes + 1, n_done, n_hits);
        $display("%0d memory reads, %0d faults, %0d rejected items; %0d mismatches.",
                 n_reads, n_faults, n_rejects, errors);
        if (errors == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

>>> filelist.f
sv/tlbw_pkg.sv
sv/tlbw_front.sv
sv/tlbw_back.sv
sv/tlb_with_two_level_page_walk.sv
sim/tlb_with_two_level_page_walk_tb.sv
